/* rtl/ccba_pkg.sv */
// ----------------------------------------------------------------------------
// ccba_pkg
// Shared constants, field widths and controller/datapath interface types for
// the contiguous chunk bitmap allocator.
// ----------------------------------------------------------------------------
package ccba_pkg;

    localparam int MAX_CHUNKS = 256;
    localparam int IDX_W      = $clog2(MAX_CHUNKS);   // chunk index
    localparam int CNT_W      = IDX_W + 1;            // chunk count, holds MAX_CHUNKS

    localparam int CB_W       = 13;                   // chunk_bytes register
    localparam int CB_MAX     = 4096;
    localparam int POOL_W     = 9;                    // chunks_in_use register
    localparam int SIZE_W     = 21;
    localparam int OFF_W      = 20;
    localparam int CHUNK_W    = 8;

    // dividend holds size + chunk_bytes - 1 without overflow
    localparam int DVD_W      = SIZE_W + 1;
    localparam int DCNT_W     = $clog2(DVD_W);

    localparam int S_TDATA_W  = ((SIZE_W + OFF_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((OFF_W + CHUNK_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = CB_W;

    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS_IN_USE = 1'b1;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic div_step;
        logic scan_init;
        logic scan_step;
        logic mark_step;
        logic free_init;
        logic free_step;
        logic res_fail;
        logic res_alloc;
        logic res_free;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic div_last;
        logic alloc_bad;
        logic free_bad;
        logic scan_end;
        logic hit;
        logic mark_last;
        logic free_last;
        logic out_free;
    } t_stat;

endpackage

/* rtl/ccba_ctrl.sv */
// ----------------------------------------------------------------------------
// ccba_ctrl
// Sequencer for one request: divide, check, scan / mark or free walk, then
// hand the result to the output register.
// ----------------------------------------------------------------------------
module ccba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  ccba_pkg::t_stat i_stat,
    output ccba_pkg::t_cmd  o_cmd
);
    import ccba_pkg::*;

    typedef enum logic [9:0] {
        ST_CLR     = 10'b0000000001,
        ST_IDLE    = 10'b0000000010,
        ST_DIV     = 10'b0000000100,
        ST_EVAL    = 10'b0000001000,
        ST_SCAN_RD = 10'b0000010000,
        ST_SCAN    = 10'b0000100000,
        ST_MARK    = 10'b0001000000,
        ST_FREE_RD = 10'b0010000000,
        ST_FREE    = 10'b0100000000,
        ST_DONE    = 10'b1000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLR: begin
                // zero the mark memory one entry per cycle
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_stat.is_free) begin
                    if (i_stat.free_bad) begin
                        o_cmd.res_fail = 1'b1;
                        n_state        = ST_DONE;
                    end else begin
                        o_cmd.free_init = 1'b1;
                        n_state         = ST_FREE_RD;
                    end
                end else begin
                    if (i_stat.alloc_bad) begin
                        o_cmd.res_fail = 1'b1;
                        n_state        = ST_DONE;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD: begin
                if (i_stat.scan_end) begin
                    o_cmd.res_fail = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.hit) begin
                    n_state = ST_MARK;
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_MARK: begin
                o_cmd.mark_step = 1'b1;
                if (i_stat.mark_last) begin
                    o_cmd.res_alloc = 1'b1;
                    n_state         = ST_DONE;
                end
            end
            ST_FREE_RD: begin
                n_state = ST_FREE;
            end
            ST_FREE: begin
                o_cmd.free_step = 1'b1;
                if (i_stat.free_last) begin
                    o_cmd.res_free = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    n_state = ST_FREE_RD;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/ccba_datapath.sv */
// ----------------------------------------------------------------------------
// ccba_datapath
// Configuration registers, mark memory, radix-2 divider, scan and walk
// pointers, result register and output register.
// ----------------------------------------------------------------------------
module ccba_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ccba_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ccba_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic [ccba_pkg::S_TDATA_W-1:0]       i_s_tdata,
    input  logic                                 i_s_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [ccba_pkg::M_TDATA_W-1:0]       o_m_tdata,
    output logic                                 o_m_tuser,
    input  ccba_pkg::t_cmd                       i_cmd,
    output ccba_pkg::t_stat                      o_stat
);
    import ccba_pkg::*;

    typedef struct packed {
        logic cont;
        logic occ;
    } t_mark;

    // configuration
    logic [CB_W-1:0]   r_chunk_bytes;
    logic [POOL_W-1:0] r_chunks_in_use;
    logic [CB_W-1:0]   w_cb;
    logic [CNT_W-1:0]  w_cnt;

    // marks
    t_mark             r_marks [MAX_CHUNKS];
    t_mark             r_rd;
    t_mark             w_mem_wdata;
    logic              w_mem_we;

    // request and divider
    logic              r_is_free;
    logic              r_size_zero;
    logic [DVD_W-1:0]  r_dvd;
    logic [DVD_W-1:0]  r_quo;
    logic [CB_W-1:0]   r_rem;
    logic [DCNT_W-1:0] r_div_cnt;
    logic [CB_W:0]     w_trial;
    logic [CB_W:0]     w_diff;
    logic              w_ge;
    logic [DVD_W-1:0]  w_size_ext;
    logic [DVD_W-1:0]  w_off_ext;

    // scan / mark / walk
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_run;
    logic [CNT_W-1:0]  r_need;
    logic [IDX_W-1:0]  r_first;
    logic [IDX_W-1:0]  r_last;
    logic [CNT_W-1:0]  w_run_inc;
    logic [IDX_W-1:0]  w_pos;
    logic [IDX_W+CB_W-1:0] w_mul;

    // result and output stage
    logic               r_res_ok;
    logic [OFF_W-1:0]   r_res_off;
    logic [CHUNK_W-1:0] r_res_chunk;
    logic               r_m_valid;
    logic               r_m_ok;
    logic [OFF_W-1:0]   r_m_off;
    logic [CHUNK_W-1:0] r_m_chunk;

    always_comb begin
        if (r_chunk_bytes == '0) begin
            w_cb = CB_W'(1);
        end else if (r_chunk_bytes > CB_W'(CB_MAX)) begin
            w_cb = CB_W'(CB_MAX);
        end else begin
            w_cb = r_chunk_bytes;
        end
        if (r_chunks_in_use == '0) begin
            w_cnt = CNT_W'(1);
        end else if (r_chunks_in_use > POOL_W'(MAX_CHUNKS)) begin
            w_cnt = CNT_W'(MAX_CHUNKS);
        end else begin
            w_cnt = CNT_W'(r_chunks_in_use);
        end
    end

    assign w_size_ext = DVD_W'(i_s_tdata[SIZE_W-1:0]);
    assign w_off_ext  = DVD_W'(i_s_tdata[SIZE_W+OFF_W-1:SIZE_W]);

    // one quotient bit per step
    assign w_trial = {r_rem, r_dvd[DVD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, w_cb});
    assign w_diff  = w_trial - {1'b0, w_cb};

    assign w_pos     = r_idx[IDX_W-1:0];
    assign w_run_inc = r_run + CNT_W'(1);
    assign w_mul     = (IDX_W+CB_W)'(r_first) * (IDX_W+CB_W)'(w_cb);

    always_comb begin
        o_stat           = '0;
        o_stat.clr_last  = (w_pos == IDX_W'(MAX_CHUNKS - 1));
        o_stat.is_free   = r_is_free;
        o_stat.div_last  = (r_div_cnt == DCNT_W'(DVD_W - 1));
        o_stat.alloc_bad = r_size_zero || (r_quo > DVD_W'(w_cnt));
        o_stat.free_bad  = (r_quo >= DVD_W'(w_cnt));
        o_stat.scan_end  = (r_idx == w_cnt);
        o_stat.hit       = !r_rd.occ && (w_run_inc == r_need);
        o_stat.mark_last = (w_pos == r_first);
        o_stat.free_last = !r_rd.cont || (w_pos == IDX_W'(MAX_CHUNKS - 1));
        o_stat.out_free  = !r_m_valid || i_m_tready;
    end

    // one write a cycle: clearing pass, run marking or free walk
    always_comb begin
        w_mem_we    = i_cmd.clr_step || i_cmd.mark_step || i_cmd.free_step;
        w_mem_wdata = '0;
        if (i_cmd.mark_step) begin
            w_mem_wdata.occ  = 1'b1;
            w_mem_wdata.cont = (w_pos != r_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_marks[w_pos] <= w_mem_wdata;
        end
        r_rd <= r_marks[w_pos];
    end

    // control state: configuration, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_bytes   <= CB_W'(16);
            r_chunks_in_use <= POOL_W'(MAX_CHUNKS);
            r_m_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CHUNK_BYTES:   r_chunk_bytes   <= i_cfg_wdata[CB_W-1:0];
                    CFG_CHUNKS_IN_USE: r_chunks_in_use <= i_cfg_wdata[POOL_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.push) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // chunk pointer: clearing pass, scan, mark and free walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            if (i_cmd.scan_init) begin
                r_idx <= '0;
            end
            if (i_cmd.scan_step && !o_stat.hit) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (i_cmd.mark_step) begin
                r_idx <= r_idx - CNT_W'(1);
            end
            if (i_cmd.free_init) begin
                r_idx <= CNT_W'(r_quo[IDX_W-1:0]);
            end
            if (i_cmd.free_step || i_cmd.clr_step) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_free   <= i_s_tuser;
            r_size_zero <= (i_s_tdata[SIZE_W-1:0] == '0);
            r_dvd       <= (i_s_tuser == REQ_FREE) ? w_off_ext
                                                   : w_size_ext + DVD_W'(w_cb) - DVD_W'(1);
            r_rem       <= '0;
            r_div_cnt   <= '0;
        end
        if (i_cmd.div_step) begin
            r_dvd     <= {r_dvd[DVD_W-2:0], 1'b0};
            r_quo     <= {r_quo[DVD_W-2:0], w_ge};
            r_rem     <= w_ge ? w_diff[CB_W-1:0] : w_trial[CB_W-1:0];
            r_div_cnt <= r_div_cnt + DCNT_W'(1);
        end
        if (i_cmd.scan_init) begin
            r_run  <= '0;
            r_need <= r_quo[CNT_W-1:0];
        end
        if (i_cmd.scan_step) begin
            if (o_stat.hit) begin
                // found the run: walk back from its last chunk
                r_first <= IDX_W'(r_idx + CNT_W'(1) - r_need);
                r_last  <= w_pos;
            end else begin
                r_run <= r_rd.occ ? '0 : w_run_inc;
            end
        end
        if (i_cmd.free_init) begin
            r_first <= r_quo[IDX_W-1:0];
        end
        if (i_cmd.res_fail) begin
            r_res_ok    <= 1'b0;
            r_res_off   <= '0;
            r_res_chunk <= '0;
        end
        if (i_cmd.res_alloc) begin
            r_res_ok    <= 1'b1;
            r_res_off   <= OFF_W'(w_mul);
            r_res_chunk <= CHUNK_W'(r_first);
        end
        if (i_cmd.res_free) begin
            r_res_ok    <= 1'b1;
            r_res_off   <= '0;
            r_res_chunk <= CHUNK_W'(r_first);
        end
        if (i_cmd.push) begin
            r_m_ok    <= r_res_ok;
            r_m_off   <= r_res_off;
            r_m_chunk <= r_res_chunk;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m_ok;
    assign o_m_tdata  = {(M_TDATA_W - OFF_W - CHUNK_W)'(0), r_m_chunk, r_m_off};

endmodule

/* rtl/contiguous_chunk_bitmap_allocator_core.sv */
// ----------------------------------------------------------------------------
// contiguous_chunk_bitmap_allocator_core
// First-fit allocator of contiguous chunk runs over a 256-chunk bitmap.
// ----------------------------------------------------------------------------
// One request is handled at a time and each gives one result beat. After
// reset a clearing pass zeroes every entry of the mark memory while
// o_s_tready stays low. Every request first runs a radix-2 divide (byte size
// to chunks, or byte offset to chunk index) and then a check state. An
// allocate then scans the marks from chunk 0, reading and then testing each
// chunk, until a fitting run ends, and marks the run one chunk per cycle. An
// allocate that finds no run is refused when the scan reaches the end of the
// pool. A free walks the continue marks, reading and then clearing each
// chunk. Requests refused at the check go straight to the result. A result
// that finds the previous beat still waiting on i_m_tready waits with it.
// o_s_tready rises as the previous result enters the output register, even
// while that beat still waits.
module contiguous_chunk_bitmap_allocator_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration writes: index 0 chunk_bytes, 1 chunks_in_use
    input  logic                                 i_cfg_we,
    input  logic [ccba_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ccba_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    // request side
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [ccba_pkg::S_TDATA_W-1:0]       i_s_tdata,  // size_bytes, offset_bytes
    input  logic                                 i_s_tuser,  // req_type
    // result side
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [ccba_pkg::M_TDATA_W-1:0]       o_m_tdata,  // region_offset, start_chunk
    output logic                                 o_m_tuser   // ok
);
    import ccba_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    ccba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ccba_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule

/* rtl/ccba_checker.sv */
// ----------------------------------------------------------------------------
// ccba_checker
// Port-level checks for the allocator core, bound to the top level.
// ----------------------------------------------------------------------------
module ccba_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [ccba_pkg::M_TDATA_W-1:0]    o_m_tdata,
    input logic                              o_m_tuser
);
    import ccba_pkg::*;

    // held beat keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result beat changed while stalled");

    // held beat stays valid
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result beat dropped while stalled");

    // one request in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request taken while another is in progress");

    // a failed request reports zero offset and chunk
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("failed result carries nonzero fields");

endmodule

bind contiguous_chunk_bitmap_allocator_core ccba_checker u_ccba_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

/* tb/sv/contiguous_chunk_bitmap_allocator_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// contiguous_chunk_bitmap_allocator_core_tb
// Self-checking bench for the first-fit contiguous chunk allocator. A
// request generator feeds a stream driver. A bitmap predictor, updated on
// every accepted request beat, queues the grant or refusal it implies. A
// monitor compares each result beat with the oldest queued outcome. The run
// covers directed corner cases and then random allocate/free traffic under
// several chunk and pool settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module contiguous_chunk_bitmap_allocator_core_tb;
    import ccba_pkg::*;

    localparam int CYCLE_LIMIT  = 6_000_000;
    localparam int HOLD_CYCLES  = 3000;
    localparam int BATCH        = 8;
    localparam int DRAIN_CYCLES = 1000;
    localparam int NUM_PHASES   = 11;

    typedef struct {
        logic               req_type;
        logic [SIZE_W-1:0]  size_bytes;
        logic [OFF_W-1:0]   offset_bytes;
    } t_request;

    typedef struct {
        logic               ok;
        logic [OFF_W-1:0]   region_offset;
        logic [CHUNK_W-1:0] start_chunk;
    } t_outcome;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = CFG_CHUNK_BYTES;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;   // size_bytes, offset_bytes
    logic                  s_tuser = 1'b0; // req_type
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;        // region_offset, start_chunk
    logic                  m_tuser;        // ok

    // predictor state and shadow registers
    logic              occ_mark  [MAX_CHUNKS];
    logic              cont_mark [MAX_CHUNKS];
    logic [CB_W-1:0]   chunk_bytes_reg = 13'd16;
    logic [POOL_W-1:0] pool_reg = 9'd256;

    t_request requests_to_send[$];
    t_outcome outcomes_due[$];

    int pushed_count = 0;
    int accepted_count = 0;
    int beats_checked = 0;
    int failures = 0;
    int grants = 0;
    int frees_done = 0;
    int refusals = 0;
    int settings_written = 0;
    int tx_idle_pct = 10;
    int rx_idle_pct = 10;
    int hold_requested = 0;
    int hold_served = 0;
    int hold_left = 0;
    int cycle_count = 0;

    contiguous_chunk_bitmap_allocator_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int eff_chunk_bytes();
        if (chunk_bytes_reg == 0) return 1;
        if (chunk_bytes_reg > CB_MAX) return CB_MAX;
        return int'(chunk_bytes_reg);
    endfunction

    function automatic int eff_pool_chunks();
        if (pool_reg == 0) return 1;
        if (pool_reg > MAX_CHUNKS) return MAX_CHUNKS;
        return int'(pool_reg);
    endfunction

    // applies one request to the bitmaps and returns the result it gives
    function automatic t_outcome allocate_or_free(t_request req);
        int       cb;
        int       pool;
        int       need;
        int       run;
        int       i;
        int       c;
        int       first;
        int       idx;
        logic     more;
        t_outcome res;
        cb   = eff_chunk_bytes();
        pool = eff_pool_chunks();
        res.ok = 1'b0;
        res.region_offset = '0;
        res.start_chunk = '0;
        if (req.req_type == REQ_ALLOC) begin
            if (req.size_bytes == 0) return res;
            need = (int'(req.size_bytes) + cb - 1) / cb;
            if (need > pool) return res;
            run = 0;
            for (i = 0; i < pool; i++) begin
                if (occ_mark[i]) begin
                    run = 0;
                end else begin
                    run++;
                    if (run == need) break;
                end
            end
            if (i >= pool) return res;
            first = i + 1 - need;
            for (c = first; c < first + need; c++) begin
                occ_mark[c]  = 1'b1;
                cont_mark[c] = (c + 1 < first + need);
            end
            res.ok = 1'b1;
            res.region_offset = OFF_W'(first * cb);
            res.start_chunk = CHUNK_W'(first);
            return res;
        end
        idx = int'(req.offset_bytes) / cb;
        if (idx >= pool) return res;
        // walk may run past the pool when it was shrunk after the allocation
        i = idx;
        do begin
            more = cont_mark[i];
            occ_mark[i]  = 1'b0;
            cont_mark[i] = 1'b0;
            i++;
        end while (more && i < MAX_CHUNKS);
        res.ok = 1'b1;
        res.start_chunk = CHUNK_W'(idx);
        return res;
    endfunction

    task automatic note_failure(string msg);
        failures++;
        if (failures <= 10) $display("ERROR @%0t: %s", $time, msg);
    endtask

    // request driver
    always @(posedge clk) begin : drive_requests
        t_request got;
        t_request nxt;
        t_outcome res;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                got.req_type     = s_tuser;
                got.size_bytes   = s_tdata[SIZE_W-1:0];
                got.offset_bytes = s_tdata[SIZE_W +: OFF_W];
                res = allocate_or_free(got);
                outcomes_due.push_back(res);
                accepted_count++;
                if (!res.ok) refusals++;
                else if (got.req_type == REQ_ALLOC) grants++;
                else frees_done++;
            end
            if (!s_tvalid || s_tready) begin
                if (requests_to_send.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    nxt = requests_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'({nxt.offset_bytes, nxt.size_bytes});
                    s_tuser  <= nxt.req_type;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk) begin : check_results
        t_outcome want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                beats_checked++;
                if (outcomes_due.size() == 0) begin
                    note_failure($sformatf("result beat with nothing pending: ok %0d data 0x%0h",
                                           m_tuser, m_tdata));
                end else begin
                    want = outcomes_due.pop_front();
                    if (m_tuser !== want.ok
                            || m_tdata[OFF_W-1:0] !== want.region_offset
                            || m_tdata[OFF_W +: CHUNK_W] !== want.start_chunk) begin
                        note_failure($sformatf(
                            "beat %0d exp ok %0d off 0x%0h chunk %0d, got ok %0d off 0x%0h chunk %0d",
                            beats_checked, want.ok, want.region_offset, want.start_chunk,
                            m_tuser, m_tdata[OFF_W-1:0], m_tdata[OFF_W +: CHUNK_W]));
                    end
                end
            end
            if (hold_served != hold_requested) begin
                hold_served = hold_requested;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, outcomes_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic queue_request(logic kind, int size, int offset);
        t_request req;
        req.req_type     = kind;
        req.size_bytes   = SIZE_W'(size);
        req.offset_bytes = OFF_W'(offset);
        requests_to_send.push_back(req);
        pushed_count++;
    endtask

    task automatic wait_accepted();
        while (accepted_count != pushed_count) @(negedge clk);
    endtask

    task automatic wait_settled(int extra);
        wait_accepted();
        while (outcomes_due.size() != 0) @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_CHUNK_BYTES) chunk_bytes_reg = CB_W'(value);
        else pool_reg = POOL_W'(value);
        settings_written++;
    endtask

    // random traffic, frees mostly aimed at run starts the bitmap holds now
    task automatic random_batch(int n);
        int cb;
        int pool;
        int starts[$];
        int c;
        int k;
        int roll;
        int n_chunks;
        int top;
        int idx;
        int size;
        int offset;
        wait_accepted();
        cb   = eff_chunk_bytes();
        pool = eff_pool_chunks();
        for (c = 0; c < MAX_CHUNKS; c++)
            if (occ_mark[c] && (c == 0 || !cont_mark[c-1])) starts.push_back(c);
        for (k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    size = 0;
                end else if (roll < 10) begin
                    size = $urandom_range(0, (1 << SIZE_W) - 1);
                end else begin
                    top = (roll < 18) ? pool + 2 : ((pool <= 8) ? pool : pool / 8 + 2);
                    n_chunks = $urandom_range(1, top);
                    size = (n_chunks - 1) * cb + $urandom_range(1, cb);
                end
                queue_request(REQ_ALLOC, size, $urandom);
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 70 && starts.size() != 0)
                    idx = starts[$urandom_range(0, starts.size() - 1)];
                else if (roll < 85)
                    idx = $urandom_range(0, pool - 1);
                else
                    idx = -1;
                if (idx < 0) offset = $urandom_range(0, (1 << OFF_W) - 1);
                else offset = idx * cb + $urandom_range(0, cb - 1);
                queue_request(REQ_FREE, $urandom, offset);
            end
        end
    endtask

    initial begin : run_stimulus
        int phase_cb    [NUM_PHASES];
        int phase_pool  [NUM_PHASES];
        int phase_items [NUM_PHASES];
        int p;
        int done;
        foreach (occ_mark[c]) begin
            occ_mark[c]  = 1'b0;
            cont_mark[c] = 1'b0;
        end
        phase_cb    = '{16, 1, 4096, 0, 7, 8191, 100, 3, 4095, 33, 16};
        phase_pool  = '{256, 8, 16, 0, 13'h1E40, 511, 32, 200, 255, 1, 256};
        phase_items = '{120, 100, 100, 60, 100, 100, 100, 100, 100, 60, 140};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: 16-byte chunks, full pool
        queue_request(REQ_ALLOC, 0, 0);            // zero size
        queue_request(REQ_ALLOC, 1, 0);
        queue_request(REQ_ALLOC, 16, 0);
        queue_request(REQ_ALLOC, 17, 0);           // two chunks
        queue_request(REQ_ALLOC, 2097151, 0);      // more chunks than the pool
        queue_request(REQ_ALLOC, 4096, 0);         // no run long enough
        queue_request(REQ_FREE, 0, 37);
        queue_request(REQ_FREE, 0, 1048575);       // offset beyond pool
        queue_request(REQ_FREE, 0, 4095);          // free of an unused chunk
        queue_request(REQ_FREE, 0, 0);
        queue_request(REQ_FREE, 0, 16);
        queue_request(REQ_ALLOC, 4096, 0);         // whole pool
        queue_request(REQ_FREE, 0, 0);
        queue_request(REQ_ALLOC, 4080, 0);
        queue_request(REQ_ALLOC, 17, 0);
        queue_request(REQ_ALLOC, 16, 0);           // last chunk
        wait_settled(30);
        write_reg(CFG_CHUNKS_IN_USE, 4);
        queue_request(REQ_FREE, 0, 0);             // walk runs past the shrunk pool
        queue_request(REQ_FREE, 0, 4080);
        wait_settled(30);
        write_reg(CFG_CHUNK_BYTES, 0);
        write_reg(CFG_CHUNKS_IN_USE, 0);
        queue_request(REQ_ALLOC, 1, 0);
        queue_request(REQ_ALLOC, 1, 0);
        queue_request(REQ_FREE, 0, 1);
        queue_request(REQ_FREE, 0, 0);
        wait_settled(30);
        write_reg(CFG_CHUNK_BYTES, 8191);          // clamps to the largest chunk
        write_reg(CFG_CHUNKS_IN_USE, 511);
        queue_request(REQ_FREE, 0, 1044480);
        queue_request(REQ_ALLOC, 1048576, 0);
        queue_request(REQ_FREE, 0, 0);

        for (p = 0; p < NUM_PHASES; p++) begin
            wait_settled(30);
            write_reg(CFG_CHUNK_BYTES, phase_cb[p]);
            write_reg(CFG_CHUNKS_IN_USE, phase_pool[p]);
            tx_idle_pct = (p == 7) ? 0 : 10;
            rx_idle_pct = (p == 7) ? 0 : 10;
            if (p == 4) hold_requested++;
            done = 0;
            while (done < phase_items[p]) begin
                // sender stops until the block has answered everything
                if (p == 1 && done == phase_items[p] / 2) wait_settled(0);
                random_batch(BATCH);
                done += BATCH;
            end
        end

        wait_settled(DRAIN_CYCLES);
        $display("%0d requests over %0d register writes: %0d grants, %0d frees, %0d refusals",
                 accepted_count, settings_written, grants, frees_done, refusals);
        $display("%0d result beats checked, %0d mismatches", beats_checked, failures);
        if (failures == 0 && outcomes_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
